### rtl/lru_keyed_cache_core_assert.svh
// ----------------------------------------------------------------------------
// lru_keyed_cache_core_assert.svh
// Assertion macros shared by the cache RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef LRU_KEYED_CACHE_CORE_ASSERT_SVH
`define LRU_KEYED_CACHE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define LKC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
// check a property on every clock edge, reset included
`define LKC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");
`else
`define LKC_ASSERT(label, clk, rst, prop)
`define LKC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### rtl/lkc_pkg.sv
// ----------------------------------------------------------------------------
// lkc_pkg
// Types and constants for the fully associative LRU keyed cache.
// ----------------------------------------------------------------------------
package lkc_pkg;

   // number of cache slots
   localparam int CACHE_ENTRIES = 16;
   localparam int IDX_W   = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int CNT_W   = $clog2(CACHE_ENTRIES + 1);
   localparam int KEY_W   = 64;
   localparam int PAY_W   = 64;
   localparam int CFG_W   = 5;
   localparam int EVICT_W = 5;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

   typedef enum logic [0:0] {
      CMD_LOOKUP = 1'b0,
      CMD_INSERT = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [KEY_W-1:0]   time_key;
      logic [PAY_W-1:0]   payload_in;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [PAY_W-1:0]   payload_out;
      logic [EVICT_W-1:0] evicted_count;
   } rsp_type;

   // control from the sequencer to the directory
   typedef struct packed {
      logic               exec;
      cmd_type            cmd;
      logic [KEY_W-1:0]   key;
   } dir_ctl_type;

   // directory decision for the beat in execution
   typedef struct packed {
      logic               hit;
      logic               lookup_hit;
      logic               store;
      logic [IDX_W-1:0]   slot;
      logic [EVICT_W-1:0] evicted;
   } dir_stat_type;

endpackage

### rtl/lkc_ram.sv
// ----------------------------------------------------------------------------
// lkc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lkc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/lkc_dir.sv
// ----------------------------------------------------------------------------
// lkc_dir
// Key directory: parallel key match, age ranks, valid marks and fill count.
// ----------------------------------------------------------------------------
`include "lru_keyed_cache_core_assert.svh"

module lkc_dir (
   input  logic                            clock,
   input  logic                            reset,
   input  lkc_pkg::dir_ctl_type            ctl,
   input  logic [lkc_pkg::CFG_W-1:0]       max_entries,
   output lkc_pkg::dir_stat_type           stat
);

   localparam int N     = lkc_pkg::CACHE_ENTRIES;
   localparam int IDX_W = lkc_pkg::IDX_W;
   localparam int CNT_W = lkc_pkg::CNT_W;

   logic [lkc_pkg::KEY_W-1:0] key_ff [N];
   logic [N-1:0]              valid_ff, valid_in;
   logic [IDX_W-1:0]          rank_ff [N];
   logic [IDX_W-1:0]          rank_in [N];
   logic [CNT_W-1:0]          cnt_ff, cnt_in;

   logic [N-1:0]     match;
   logic [N-1:0]     evict;
   logic [N-1:0]     valid_keep;
   logic             hit_any;
   logic             is_insert;
   logic             cap_zero;
   logic             do_promote;
   logic             do_new;
   logic [IDX_W-1:0] hit_idx;
   logic [IDX_W-1:0] free_idx;
   logic [IDX_W-1:0] hit_rank;
   logic [IDX_W-1:0] cap_m1;
   logic [CNT_W-1:0] cap;
   logic [CNT_W-1:0] evict_n;

   // clamp capacity to the slot count
   always_comb begin
      if (32'(max_entries) > 32'(N)) begin
         cap = CNT_W'(N);
      end else begin
         cap = CNT_W'(max_entries);
      end
   end

   assign cap_m1 = IDX_W'(cap - CNT_W'(1));

   // compare the key against every valid slot
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < N; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == ctl.key);
         if (match[i]) begin
            hit_idx = hit_idx | IDX_W'(i);
         end
      end
   end

   assign hit_any    = |match;
   assign hit_rank   = rank_ff[hit_idx];
   assign is_insert  = (ctl.cmd == lkc_pkg::CMD_INSERT);
   assign cap_zero   = (cap == '0);
   assign do_promote = hit_any && (!is_insert || !cap_zero);
   assign do_new     = is_insert && !cap_zero && !hit_any;

   // mark the oldest slots that must go so the new entry fits
   always_comb begin
      for (int i = 0; i < N; i++) begin
         evict[i] = do_new && valid_ff[i] && (rank_ff[i] >= cap_m1);
      end
   end

   assign valid_keep = valid_ff & ~evict;
   assign evict_n    = CNT_W'($countones(evict));

   // pick the lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (!valid_keep[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   // next ranks, valid marks and count
   always_comb begin
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      for (int i = 0; i < N; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (do_promote) begin
         for (int i = 0; i < N; i++) begin
            if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
               rank_in[i] = rank_ff[i] + IDX_W'(1);
            end
         end
         rank_in[hit_idx] = '0;
      end else if (do_new) begin
         for (int i = 0; i < N; i++) begin
            if (valid_keep[i]) begin
               rank_in[i] = rank_ff[i] + IDX_W'(1);
            end else if (evict[i]) begin
               rank_in[i] = '0;
            end
         end
         valid_in           = valid_keep;
         valid_in[free_idx] = 1'b1;
         rank_in[free_idx]  = '0;
         cnt_in             = cnt_ff - evict_n + CNT_W'(1);
      end
   end

   // commit at the end of the execute cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cnt_ff   <= '0;
         for (int i = 0; i < N; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (ctl.exec) begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
         for (int i = 0; i < N; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // store the key of a new entry
   always_ff @(posedge clock) begin
      if (ctl.exec && do_new) begin
         key_ff[free_idx] <= ctl.key;
      end
   end

   // report the decision to the sequencer
   always_comb begin
      stat.hit        = do_promote;
      stat.lookup_hit = hit_any && !is_insert;
      stat.store      = is_insert && !cap_zero;
      stat.slot       = hit_any ? hit_idx : free_idx;
      if (!do_new) begin
         stat.evicted = '0;
      end else if (32'(evict_n) > 32'((1 << lkc_pkg::EVICT_W) - 1)) begin
         stat.evicted = '1;
      end else begin
         stat.evicted = lkc_pkg::EVICT_W'(evict_n);
      end
   end

   `LKC_ASSERT(a_count_in_range, clock, reset, cnt_ff <= CNT_W'(N))
   `LKC_ASSERT(a_count_tracks_valid, clock, reset, $countones(valid_ff) == 32'(cnt_ff))
   `LKC_ASSERT(a_key_unique, clock, reset, (ctl.exec && hit_any) |-> $onehot(match))

endmodule

### rtl/lru_keyed_cache_core.sv
// ----------------------------------------------------------------------------
// lru_keyed_cache_core
// A beat taken at start passes the execute state, then the response state,
// which shows its result strobe and can take a new beat. Busy is high for the
// execute cycle: key match, rank update and payload RAM access happen there.
// Reset clears valid marks, ranks and count, and sets capacity to 16.
// Results cannot be stalled; each one is shown for a single cycle.
// ----------------------------------------------------------------------------
`include "lru_keyed_cache_core_assert.svh"

module lru_keyed_cache_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lkc_pkg::req_type              req_data,
   output logic                          rsp_strobe,
   output lkc_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lkc_pkg::CFG_W-1:0]     csr_wdata
);

   lkc_pkg::state_type      state_ff, state_in;
   lkc_pkg::req_type        req_ff;
   logic [lkc_pkg::CFG_W-1:0] max_ff;
   logic                    hit_ff;
   logic                    lookup_hit_ff;
   logic [lkc_pkg::EVICT_W-1:0] evict_ff;
   logic                    exec;
   logic                    accept;
   lkc_pkg::dir_ctl_type    ctl;
   lkc_pkg::dir_stat_type   stat;
   logic [lkc_pkg::PAY_W-1:0] ram_rdata;

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= lkc_pkg::CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         max_ff <= csr_wdata;
      end
   end

   // next state
   always_comb begin
      case (state_ff)
         lkc_pkg::ST_IDLE: state_in = start ? lkc_pkg::ST_EXEC : lkc_pkg::ST_IDLE;
         lkc_pkg::ST_EXEC: state_in = lkc_pkg::ST_RESP;
         lkc_pkg::ST_RESP: state_in = start ? lkc_pkg::ST_EXEC : lkc_pkg::ST_IDLE;
         default:          state_in = lkc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lkc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // state outputs
   always_comb begin
      case (state_ff)
         lkc_pkg::ST_EXEC: begin
            busy       = 1'b1;
            exec       = 1'b1;
            rsp_strobe = 1'b0;
         end
         lkc_pkg::ST_RESP: begin
            busy       = 1'b0;
            exec       = 1'b0;
            rsp_strobe = 1'b1;
         end
         default: begin
            busy       = 1'b0;
            exec       = 1'b0;
            rsp_strobe = 1'b0;
         end
      endcase
   end

   // hold the request beat
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   assign ctl.exec = exec;
   assign ctl.cmd  = req_ff.cmd;
   assign ctl.key  = req_ff.time_key;

   lkc_dir u_dir (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .max_entries (max_ff),
      .stat        (stat)
   );

   // payload store: write on insert, read the hit slot on lookup
   lkc_ram #(
      .WIDTH (lkc_pkg::PAY_W),
      .DEPTH (lkc_pkg::CACHE_ENTRIES)
   ) u_payload_ram (
      .clock (clock),
      .we    (exec && stat.store),
      .waddr (stat.slot),
      .wdata (req_ff.payload_in),
      .raddr (stat.slot),
      .rdata (ram_rdata)
   );

   // capture result flags at the end of execute
   always_ff @(posedge clock) begin
      if (exec) begin
         hit_ff        <= stat.hit;
         lookup_hit_ff <= stat.lookup_hit;
         evict_ff      <= stat.evicted;
      end
   end

   assign rsp_data.hit           = hit_ff;
   assign rsp_data.payload_out   = lookup_hit_ff ? ram_rdata : '0;
   assign rsp_data.evicted_count = evict_ff;

   `LKC_ASSERT(a_strobe_gap, clock, reset, rsp_strobe |=> !rsp_strobe)
   `LKC_ASSERT(a_result_follows, clock, reset, (start && !busy) |-> ##2 rsp_strobe)
   `LKC_ASSERT(a_miss_zero_payload, clock, reset, (rsp_strobe && !rsp_data.hit) |-> (rsp_data.payload_out == '0))

endmodule

### test/tb_lru_keyed_cache_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_keyed_cache_core
// Self-checking bench for the fully associative LRU keyed cache. Every
// request beat accepted by the core is run through a behavioral copy of the
// cache, and the expected response is queued. Each response strobe is then
// compared field by field with the oldest queued response. A directed part
// covers key and payload extremes, hits, misses, overwrites, multi-entry
// eviction, zero capacity and capacity saturation. Random phases then reuse
// a small key pool so that hits, promotions and evictions occur often, under
// several capacity settings.
// ----------------------------------------------------------------------------
module tb_lru_keyed_cache_core;
   import lkc_pkg::*;

   localparam int WATCHDOG_LIMIT = 500;
   localparam int POOL_SIZE      = 24;
   localparam int PHASE_ITEMS    = 92;

   // Behavioral copy of the cache with the queue of expected responses
   class cache_scoreboard;
      bit               slot_used [CACHE_ENTRIES];
      bit [KEY_W-1:0]   slot_key  [CACHE_ENTRIES];
      bit [PAY_W-1:0]   slot_pay  [CACHE_ENTRIES];
      int unsigned      slot_rank [CACHE_ENTRIES];
      int unsigned      used_count;
      bit [CFG_W-1:0]   capacity;
      rsp_type          expected_q [$];
      int               mismatches;

      function new();
         for (int i = 0; i < CACHE_ENTRIES; i++) begin
            slot_used[i] = 1'b0;
            slot_rank[i] = 0;
         end
         used_count = 0;
         capacity   = CFG_RESET;
         mismatches = 0;
      endfunction

      function void set_capacity(bit [CFG_W-1:0] value);
         capacity = value;
      endfunction

      // Make slot s the most recent; younger slots age by one
      function void promote_slot(int s);
         int unsigned r;
         r = slot_rank[s];
         for (int i = 0; i < CACHE_ENTRIES; i++)
            if (slot_used[i] && slot_rank[i] < r)
               slot_rank[i]++;
         slot_rank[s] = 0;
      endfunction

      function void note_request(req_type r);
         rsp_type     e;
         int          s;
         int          oldest;
         int          free_slot;
         int unsigned cap;
         int unsigned evicted;
         e       = '0;
         evicted = 0;
         cap     = (capacity > CACHE_ENTRIES) ? CACHE_ENTRIES : capacity;
         s       = -1;
         for (int i = 0; i < CACHE_ENTRIES; i++)
            if (s < 0 && slot_used[i] && slot_key[i] == r.time_key)
               s = i;

         if (r.cmd == CMD_LOOKUP) begin
            if (s >= 0) begin
               e.hit         = 1'b1;
               e.payload_out = slot_pay[s];
               promote_slot(s);
            end
         end else if (cap != 0) begin
            if (s >= 0) begin
               e.hit       = 1'b1;
               slot_pay[s] = r.payload_in;
               promote_slot(s);
            end else begin
               // drop least recent entries until there is room
               while (used_count >= cap && used_count > 0) begin
                  oldest = -1;
                  for (int i = 0; i < CACHE_ENTRIES; i++)
                     if (slot_used[i] && (oldest < 0 || slot_rank[i] > slot_rank[oldest]))
                        oldest = i;
                  if (oldest >= 0) begin
                     slot_used[oldest] = 1'b0;
                     slot_rank[oldest] = 0;
                     used_count--;
                  end
                  evicted++;
               end
               free_slot = -1;
               for (int i = 0; i < CACHE_ENTRIES; i++)
                  if (free_slot < 0 && !slot_used[i])
                     free_slot = i;
               if (free_slot >= 0) begin
                  for (int i = 0; i < CACHE_ENTRIES; i++)
                     if (slot_used[i])
                        slot_rank[i]++;
                  slot_used[free_slot] = 1'b1;
                  slot_key[free_slot]  = r.time_key;
                  slot_pay[free_slot]  = r.payload_in;
                  slot_rank[free_slot] = 0;
                  used_count++;
               end
            end
         end
         e.evicted_count = (evicted > 31) ? EVICT_W'(31) : EVICT_W'(evicted);
         expected_q.push_back(e);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with none expected: hit=%0b pay=%h evict=%0d",
                        $realtime, a.hit, a.payload_out, a.evicted_count);
            return;
         end
         e = expected_q.pop_front();
         if (a.hit !== e.hit || a.payload_out !== e.payload_out ||
             a.evicted_count !== e.evicted_count) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch: expected hit=%0b pay=%h evict=%0d, got hit=%0b pay=%h evict=%0d",
                        $realtime, e.hit, e.payload_out, e.evicted_count,
                        a.hit, a.payload_out, a.evicted_count);
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_strobe;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_wdata;

   cache_scoreboard  sb;
   bit [KEY_W-1:0]   key_pool [POOL_SIZE];
   bit [KEY_W-1:0]   fill_key;

   lru_keyed_cache_core uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit [63:0] random_word();
      bit [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: w = '0;
         1: w = '1;
         default: ;
      endcase
      return w;
   endfunction

   // Present one request beat and hold it until the core takes it
   task automatic send_request(cmd_type cmd, bit [KEY_W-1:0] key,
                               bit [PAY_W-1:0] pay, bit allow_idle);
      req_type r;
      r.cmd        = cmd;
      r.time_key   = key;
      r.payload_in = pay;
      req_data <= r;
      start    <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      sb.note_request(r);
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Drop start, then wait until every response is in and the core settles
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(bit [CFG_W-1:0] value, bit allow_idle);
      if (allow_idle)
         repeat ($urandom_range(1, 5)) @(posedge clock);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_capacity(value);
   endtask

   // Check every response beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_response(rsp_data);
   end

   // Stop the run when nothing moves for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      bit             no_idle;
      bit [KEY_W-1:0] key;
      bit [CFG_W-1:0] phase_cap [6];
      sb = new();
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_wdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: miss on empty cache, key and payload extremes
      send_request(CMD_LOOKUP, '0, '1, 1'b0);
      send_request(CMD_INSERT, '0, '1, 1'b0);
      send_request(CMD_INSERT, '1, '0, 1'b0);
      send_request(CMD_LOOKUP, '0, '0, 1'b0);
      // overwrite a present key, then read it back
      send_request(CMD_INSERT, '1, 64'h5A5A_A5A5_0F0F_F0F0, 1'b0);
      send_request(CMD_LOOKUP, '1, '0, 1'b0);
      // fill to the full slot count, then push one past it
      repeat (14) begin
         fill_key = {$urandom, $urandom};
         send_request(CMD_INSERT, fill_key, {$urandom, $urandom}, 1'b1);
      end
      send_request(CMD_INSERT, 64'h0123_4567_89AB_CDEF, '1, 1'b0);
      send_request(CMD_LOOKUP, '0, '0, 1'b0);
      drain();

      // Capacity lowered below the count: one insert evicts many
      write_capacity(5'd3, 1'b0);
      send_request(CMD_INSERT, 64'hFEDC_BA98_7654_3210, '0, 1'b0);
      send_request(CMD_LOOKUP, fill_key, '0, 1'b0);
      drain();

      // Zero capacity: inserts do nothing, lookups still hit
      write_capacity(5'd0, 1'b0);
      send_request(CMD_INSERT, 64'h1111_2222_3333_4444, '1, 1'b0);
      send_request(CMD_INSERT, 64'hFEDC_BA98_7654_3210, '1, 1'b0);
      send_request(CMD_LOOKUP, 64'hFEDC_BA98_7654_3210, '0, 1'b0);
      drain();

      // Capacity above the slot count saturates
      write_capacity(5'd31, 1'b1);
      send_request(CMD_INSERT, 64'h1111_2222_3333_4444, '1, 1'b0);
      drain();

      // Random phases under varied capacities; the last one runs without gaps
      phase_cap[0] = 5'd16;
      phase_cap[1] = 5'd4;
      phase_cap[2] = 5'd1;
      phase_cap[3] = 5'd0;
      phase_cap[4] = CFG_W'($urandom_range(2, 31));
      phase_cap[5] = 5'd31;
      for (int p = 0; p < 6; p++) begin
         no_idle = (p == 5);
         write_capacity(phase_cap[p], !no_idle);
         // refresh the key pool so hits and evictions stay frequent
         for (int k = 0; k < POOL_SIZE; k++)
            key_pool[k] = random_word();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 6) == 0)
               key = {$urandom, $urandom};
            else
               key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_request(cmd_type'($urandom_range(0, 1)), key, random_word(), !no_idle);
         end
         drain();
      end

      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
